### src/xcrc_pkg.sv
// Package for the XMODEM-CRC sender: codes, phases, queue entry type, CRC step.
// No dependencies.
package xcrc_pkg;

  localparam int unsigned FramePayload = 128;

  localparam logic [7:0] ChSoh = 8'h01;
  localparam logic [7:0] ChEot = 8'h04;
  localparam logic [7:0] ChAck = 8'h06;
  localparam logic [7:0] ChNak = 8'h15;
  localparam logic [7:0] ChCan = 8'h18;
  localparam logic [7:0] ChC   = 8'h43;
  localparam logic [7:0] ChLf  = 8'h0A;
  localparam logic [7:0] ChPad = 8'h1A;

  localparam logic [7:0] TimeoutReset = 8'd3;
  localparam logic [7:0] MaxNakReset  = 8'd16;

  typedef enum logic [2:0] {
    OpStart = 3'd0,
    OpData  = 3'd1,
    OpRx    = 3'd2,
    OpSlot  = 3'd3,
    OpTick  = 3'd4
  } op_e;

  typedef enum logic [0:0] {
    RegTimeout = 1'b0,
    RegMaxNaks = 1'b1
  } reg_e;

  typedef enum logic [10:0] {
    PhIdle   = 11'b000_0000_0001,
    PhWstart = 11'b000_0000_0010,
    PhFill   = 11'b000_0000_0100,
    PhSend   = 11'b000_0000_1000,
    PhWresp  = 11'b000_0001_0000,
    PhEots   = 11'b000_0010_0000,
    PhEotw   = 11'b000_0100_0000,
    PhDone   = 11'b000_1000_0000,
    PhTmo    = 11'b001_0000_0000,
    PhCan    = 11'b010_0000_0000,
    PhNaks   = 11'b100_0000_0000
  } phase_e;

  typedef enum logic [2:0] {
    StIdle = 3'd0,
    StBusy = 3'd1,
    StDone = 3'd2,
    StTmo  = 3'd3,
    StCan  = 3'd4,
    StNaks = 3'd5
  } status_e;

  // queue entry between front and back
  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

### src/xcrc_ram.sv
// Generic simple dual-port RAM (one write, one read port) with registered read.
// No dependencies.
module xcrc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### src/xcrc_front.sv
// Front end: accepts items and holds a two-entry queue towards the back end.
// Depends on xcrc_pkg.
module xcrc_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  xcrc_pkg::item_t item_i,
  output logic           q_valid_o,
  input  logic           q_ready_i,
  output xcrc_pkg::item_t q_item_o
);
  import xcrc_pkg::*;

  item_t      ent_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       rd_q, rd_d, wr_q, wr_d;
  logic       push, pop;

  assign in_ready_o = cnt_q != 2'd2;
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = cnt_q != 2'd0;
  assign q_item_o   = ent_q[rd_q];
  assign pop        = q_valid_o && q_ready_i;

  always_comb begin
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
    rd_d  = rd_q ^ pop;
    wr_d  = wr_q ^ push;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
      wr_q  <= wr_d;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count overflow");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> (rd_q != wr_q)) else $error("queue pointers disagree with count");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |=> (cnt_q != 2'd3)) else $error("pop from empty queue");
endmodule

### src/xcrc_back.sv
// Back end: protocol sequencer, frame buffer, CRC and result register.
// Depends on xcrc_pkg and xcrc_ram.
module xcrc_back #(
  parameter int unsigned FramePayload = xcrc_pkg::FramePayload
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [7:0]      cfg_data_i,
  input  logic            q_valid_i,
  output logic            q_ready_o,
  input  xcrc_pkg::item_t q_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            tx_valid_o,
  output logic [7:0]      tx_byte_o,
  output logic            data_taken_o,
  output logic            need_data_o,
  output logic            packet_acked_o,
  output logic [7:0]      frame_number_o,
  output logic [2:0]      status_o
);
  import xcrc_pkg::*;

  localparam int unsigned AW = $clog2(FramePayload);
  localparam logic [7:0] LastPay = 8'(2 + FramePayload);
  localparam logic [7:0] CrcHi   = 8'(3 + FramePayload);
  localparam logic [7:0] Full    = 8'(FramePayload);

  // A payload slot needs the RAM read issued ahead, as the read is registered.
  // The back part always pre-reads the entry for the next emit position, so
  // one item per cycle holds but for stalls: rdata always matches emit_index.
  logic [7:0] tmo_q, nakmax_q;
  phase_e     ph_q, ph_d;
  logic [7:0] fill_q, fill_d, fc_q, fc_d, nak_q, nak_d, sec_q, sec_d, ei_q, ei_d;
  logic [15:0] crc_q, crc_d;
  logic       fin_q, fin_d;
  logic       ov_q;
  logic       r_txv_q, r_take_q, r_ack_q;
  logic [7:0] r_txb_q;
  logic       txv, take, ack;
  logic [7:0] txb, sec_inc, pos, rpos;
  logic       fire, we;
  logic [7:0] rdata;
  logic [AW-1:0] raddr;

  assign q_ready_o = !ov_q || out_ready_i;
  assign fire      = q_valid_i && q_ready_o;
  assign sec_inc   = (sec_q == 8'hFF) ? sec_q : sec_q + 8'd1;
  assign pos       = ei_q - 8'd3;

  always_comb begin
    ph_d = ph_q; fill_d = fill_q; fc_d = fc_q; nak_d = nak_q; sec_d = sec_q;
    ei_d = ei_q; crc_d = crc_q; fin_d = fin_q;
    txv = 1'b0; txb = 8'h00; take = 1'b0; ack = 1'b0; we = 1'b0;
    if (fire) begin
      case (q_item_i.opcode)
        OpStart: begin
          ph_d = PhWstart; fc_d = 8'd1; nak_d = '0; sec_d = '0; fill_d = '0;
          fin_d = 1'b0; ei_d = '0; crc_d = '0;
        end
        OpData: begin
          if (ph_q == PhFill && fill_q < Full) begin
            we = 1'b1; take = 1'b1;
            fill_d = fill_q + 8'd1;
            if (q_item_i.last_byte || fill_d >= Full) begin
              fin_d = q_item_i.last_byte; nak_d = '0;
              ph_d = PhSend; ei_d = '0; crc_d = '0;
            end
          end
        end
        OpRx: begin
          if (ph_q == PhWstart) begin
            if (q_item_i.data_byte == ChC) begin
              ph_d = PhFill; fill_d = '0; sec_d = '0;
            end
          end else if (ph_q == PhWresp) begin
            if (q_item_i.data_byte == ChAck) begin
              ack = 1'b1; fc_d = fc_q + 8'd1; nak_d = '0; sec_d = '0;
              if (fin_q) begin
                ph_d = PhEots;
              end else begin
                ph_d = PhFill; fill_d = '0;
              end
            end else if (q_item_i.data_byte == ChNak) begin
              if (nak_q >= nakmax_q) begin
                ph_d = PhNaks;
              end else begin
                nak_d = nak_q + 8'd1; ph_d = PhSend; ei_d = '0; crc_d = '0;
              end
            end else if (q_item_i.data_byte == ChCan) begin
              ph_d = PhCan;
            end else if (q_item_i.data_byte == ChC || q_item_i.data_byte == ChLf) begin
              ph_d = PhSend; ei_d = '0; crc_d = '0;
            end
          end else if (ph_q == PhEotw) begin
            if (q_item_i.data_byte == ChAck) begin
              ph_d = PhDone;
            end else if (q_item_i.data_byte == ChNak || q_item_i.data_byte == ChCan ||
                         q_item_i.data_byte == ChC || q_item_i.data_byte == ChLf) begin
              ph_d = PhEots;
            end
          end
        end
        OpSlot: begin
          if (ph_q == PhSend) begin
            txv = 1'b1;
            if (ei_q == 8'd0) begin
              txb = ChSoh;
            end else if (ei_q == 8'd1) begin
              txb = fc_q;
            end else if (ei_q == 8'd2) begin
              txb = ~fc_q;
            end else if (ei_q <= LastPay) begin
              txb = (pos < fill_q) ? rdata : ChPad;
              crc_d = crc_step(crc_q, txb);
            end else if (ei_q == CrcHi) begin
              txb = crc_q[15:8];
            end else begin
              txb = crc_q[7:0];
            end
            if (ei_q > CrcHi) begin
              ph_d = PhWresp; sec_d = '0; ei_d = '0;
            end else begin
              ei_d = ei_q + 8'd1;
            end
          end else if (ph_q == PhEots) begin
            txv = 1'b1; txb = ChEot; ph_d = PhEotw;
          end
        end
        OpTick: begin
          if (ph_q == PhWstart || ph_q == PhWresp || ph_q == PhEots || ph_q == PhEotw) begin
            sec_d = sec_inc;
            if (sec_inc >= tmo_q) begin
              ph_d = PhTmo;
            end
          end
        end
        default: ;
      endcase
    end
    // pre-read the payload entry for the next emit position
    rpos  = ei_d - 8'd3;
    raddr = rpos[AW-1:0];
  end

  xcrc_ram #(.Width(8), .Depth(FramePayload)) u_buf (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (fill_q[AW-1:0]),
    .wdata_i (q_item_i.data_byte),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (fire) begin
      r_txv_q <= txv; r_txb_q <= txb; r_take_q <= take; r_ack_q <= ack;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmo_q <= TimeoutReset; nakmax_q <= MaxNakReset;
      ph_q <= PhIdle; fill_q <= '0; fc_q <= 8'd1; nak_q <= '0; sec_q <= '0;
      ei_q <= '0; crc_q <= '0; fin_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (reg_e'(cfg_idx_i))
          RegTimeout: tmo_q <= cfg_data_i;
          RegMaxNaks: nakmax_q <= cfg_data_i;
          default: ;
        endcase
      end
      ph_q <= ph_d; fill_q <= fill_d; fc_q <= fc_d; nak_q <= nak_d; sec_q <= sec_d;
      ei_q <= ei_d; crc_q <= crc_d; fin_q <= fin_d;
      if (fire) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_comb begin
    case (ph_q)
      PhIdle:  status_o = StIdle;
      PhDone:  status_o = StDone;
      PhTmo:   status_o = StTmo;
      PhCan:   status_o = StCan;
      PhNaks:  status_o = StNaks;
      default: status_o = StBusy;
    endcase
  end

  assign out_valid_o    = ov_q;
  assign tx_valid_o     = r_txv_q;
  assign tx_byte_o      = r_txb_q;
  assign data_taken_o   = r_take_q;
  assign packet_acked_o = r_ack_q;
  assign need_data_o    = ph_q == PhFill;
  assign frame_number_o = fc_q;

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(ph_q))
    else $error("phase not one-hot");
  a_fill_cap: assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= Full)
    else $error("fill count beyond frame");
  a_emit_cap: assert property (@(posedge clk_i) disable iff (!rst_ni) ei_q <= CrcHi + 8'd1)
    else $error("emit index beyond frame");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready_i) |=> !$past(fire) || ov_q) else $error("result lost");
endmodule

### src/xmodem_crc_sender_unit.sv
// XMODEM-CRC sender top level: front queue and protocol back end.
// Depends on xcrc_pkg, xcrc_front, xcrc_back.
//
// Usage: each input beat carries an opcode (start, payload byte, received
// byte, transmit slot, one-second tick) with data_byte_i and last_byte_i.
// Every input beat gives exactly one result beat on the output channel:
// tx_valid_o/tx_byte_o for the transmit slot, data_taken_o, need_data_o,
// packet_acked_o, frame_number_o and status_o. Unknown opcodes change no
// state but still give a result.
// Results pass through the front queue and then the result register.
// Throughput: one beat per cycle while the receiver takes results, as the
// sequencer step does its byte-wide CRC and buffer read together.
// Configuration: cfg_we_i writes timeout seconds (index 0) or NAK limit
// (index 1); write only while the unit is idle.
// Reset clears the phase to idle and registers to 3 s and 16 NAKs.
// When the receiver stalls, the result register holds and the front queue
// fills; in_ready_o drops once the two-entry queue is full.
module xmodem_crc_sender_unit #(
  parameter int unsigned FramePayload = xcrc_pkg::FramePayload
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] opcode_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       tx_valid_o,
  output logic [7:0] tx_byte_o,
  output logic       data_taken_o,
  output logic       need_data_o,
  output logic       packet_acked_o,
  output logic [7:0] frame_number_o,
  output logic [2:0] status_o
);
  import xcrc_pkg::*;

  item_t in_item, q_item;
  logic  q_valid, q_ready;

  assign in_item = '{opcode: opcode_i, data_byte: data_byte_i, last_byte: last_byte_i};

  xcrc_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .item_i    (in_item),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_item_o  (q_item)
  );

  xcrc_back #(.FramePayload(FramePayload)) u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .q_valid_i (q_valid),
    .q_ready_o (q_ready),
    .q_item_i  (q_item),
    .out_valid_o, .out_ready_i, .tx_valid_o, .tx_byte_o, .data_taken_o,
    .need_data_o, .packet_acked_o, .frame_number_o, .status_o
  );
endmodule

### tb/xcrc_checker.sv
// Result checker for the XMODEM-CRC sender: watches the input, result and register ports,
// keeps its own copy of the protocol state, and compares every result beat.
// Depends on xcrc_pkg.
`timescale 1ns / 1ps

module xcrc_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [2:0] opcode_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic       tx_valid_i,
  input  logic [7:0] tx_byte_i,
  input  logic       data_taken_i,
  input  logic       need_data_i,
  input  logic       packet_acked_i,
  input  logic [7:0] frame_number_i,
  input  logic [2:0] status_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         compared_o
);
  import xcrc_pkg::*;

  typedef struct packed {
    logic       txv;
    logic [7:0] txb;
    logic       taken;
    logic       need;
    logic       acked;
    logic [7:0] fnum;
    logic [2:0] st;
  } link_result_t;

  link_result_t link_results_q[$];

  logic [7:0]  tmo_secs, nak_limit;
  phase_e      ph;
  logic [7:0]  frame_buf[FramePayload];
  logic [7:0]  fill, fcnt, naks, secs, idx;
  logic [15:0] crc;
  logic        last_frame;

  function automatic logic [15:0] crc16_xmodem(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
    return r;
  endfunction

  task automatic sender_step(input logic [2:0] op, input logic [7:0] db, input logic lst);
    link_result_t r;
    int k;
    r = '0;
    case (op)
      OpStart: begin
        ph = PhWstart; fcnt = 8'd1; naks = '0; secs = '0; fill = '0;
        last_frame = 1'b0; idx = '0; crc = '0;
      end
      OpData: begin
        if (ph == PhFill && fill < FramePayload) begin
          frame_buf[fill] = db;
          fill++;
          r.taken = 1'b1;
          if (lst || fill >= FramePayload) begin
            last_frame = lst; naks = '0; ph = PhSend; idx = '0; crc = '0;
          end
        end
      end
      OpRx: begin
        if (ph == PhWstart) begin
          if (db == ChC) begin
            ph = PhFill; fill = '0; secs = '0;
          end
        end else if (ph == PhWresp) begin
          if (db == ChAck) begin
            r.acked = 1'b1; fcnt++; naks = '0; secs = '0;
            if (last_frame) ph = PhEots;
            else begin
              ph = PhFill; fill = '0;
            end
          end else if (db == ChNak) begin
            if (naks >= nak_limit) ph = PhNaks;
            else begin
              naks++; ph = PhSend; idx = '0; crc = '0;
            end
          end else if (db == ChCan) begin
            ph = PhCan;
          end else if (db == ChC || db == ChLf) begin
            ph = PhSend; idx = '0; crc = '0;
          end
        end else if (ph == PhEotw) begin
          if (db == ChAck) ph = PhDone;
          else if (db == ChNak || db == ChCan || db == ChC || db == ChLf) ph = PhEots;
        end
      end
      OpSlot: begin
        if (ph == PhSend) begin
          k = idx;
          r.txv = 1'b1;
          if (k == 0) r.txb = ChSoh;
          else if (k == 1) r.txb = fcnt;
          else if (k == 2) r.txb = 8'hFF - fcnt;
          else if (k < 3 + FramePayload) begin
            r.txb = (k - 3 < fill) ? frame_buf[k - 3] : ChPad;
            crc = crc16_xmodem(crc, r.txb);
          end else if (k == 3 + FramePayload) r.txb = crc[15:8];
          else r.txb = crc[7:0];
          if (k >= 4 + FramePayload) begin
            ph = PhWresp; secs = '0; idx = '0;
          end else begin
            idx++;
          end
        end else if (ph == PhEots) begin
          r.txv = 1'b1; r.txb = ChEot; ph = PhEotw;
        end
      end
      OpTick: begin
        if (ph inside {PhWstart, PhWresp, PhEots, PhEotw}) begin
          if (secs < 8'd255) secs++;
          if (secs >= tmo_secs) ph = PhTmo;
        end
      end
      default: ;  // unknown opcode: no state change, result still due
    endcase
    r.need = (ph == PhFill);
    r.fnum = fcnt;
    case (ph)
      PhIdle:  r.st = StIdle;
      PhDone:  r.st = StDone;
      PhTmo:   r.st = StTmo;
      PhCan:   r.st = StCan;
      PhNaks:  r.st = StNaks;
      default: r.st = StBusy;
    endcase
    link_results_q.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    link_result_t got, want;
    if (!rst_ni) begin
      tmo_secs = TimeoutReset; nak_limit = MaxNakReset;
      ph = PhIdle; fill = '0; fcnt = 8'd1; naks = '0; secs = '0; idx = '0;
      crc = '0; last_frame = 1'b0;
      link_results_q.delete();
      fail_count_o = 0; compared_o = 0; pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegTimeout) tmo_secs = cfg_data_i;
        else nak_limit = cfg_data_i;
      end
      // compare before predicting: a beat in never shows up in the same cycle
      if (out_valid_i && out_ready_i) begin
        got = '{tx_valid_i, tx_byte_i, data_taken_i, need_data_i, packet_acked_i,
                frame_number_i, status_i};
        if (link_results_q.size() == 0) begin
          $display("%0t: result beat with none expected: %h", $time, got);
          fail_count_o++;
        end else begin
          want = link_results_q.pop_front();
          compared_o++;
          if (got != want) begin
            $display("%0t: mismatch expected txv=%b txb=%h taken=%b need=%b acked=%b fn=%h st=%0d",
                     $time, want.txv, want.txb, want.taken, want.need, want.acked,
                     want.fnum, want.st);
            $display("%0t:          actual   txv=%b txb=%h taken=%b need=%b acked=%b fn=%h st=%0d",
                     $time, got.txv, got.txb, got.taken, got.need, got.acked,
                     got.fnum, got.st);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) sender_step(opcode_i, data_byte_i, last_byte_i);
      pending_o = link_results_q.size();
    end
  end

endmodule

### tb/xmodem_crc_sender_unit_tb.sv
// Top of the XMODEM-CRC sender testbench: clock, reset, stimulus and verdict.
// Depends on xcrc_pkg, xmodem_crc_sender_unit and xcrc_checker.
`timescale 1ns / 1ps

module xmodem_crc_sender_unit_tb;
  import xcrc_pkg::*;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we = 1'b0;
  logic       cfg_idx = 1'b0;
  logic [7:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic [2:0] opcode = '0;
  logic [7:0] data_byte = '0;
  logic       last_byte = 1'b0;
  logic       out_ready = 1'b0;
  logic       in_ready, out_valid, tx_valid, data_taken, need_data, packet_acked;
  logic [7:0] tx_byte, frame_number;
  logic [2:0] status;
  int         fail_count, pending, compared;

  int snd_idle, rcv_idle, beats_sent, hold_left, transfers;
  bit long_hold_req;

  xmodem_crc_sender_unit uut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .opcode_i(opcode), .data_byte_i(data_byte), .last_byte_i(last_byte),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .tx_valid_o(tx_valid), .tx_byte_o(tx_byte), .data_taken_o(data_taken),
    .need_data_o(need_data), .packet_acked_o(packet_acked),
    .frame_number_o(frame_number), .status_o(status)
  );

  xcrc_checker chk (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .opcode_i(opcode), .data_byte_i(data_byte), .last_byte_i(last_byte),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .tx_valid_i(tx_valid), .tx_byte_i(tx_byte), .data_taken_i(data_taken),
    .need_data_i(need_data), .packet_acked_i(packet_acked),
    .frame_number_i(frame_number), .status_i(status),
    .fail_count_o(fail_count), .pending_o(pending), .compared_o(compared)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = 300;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  initial begin
    #20ms;
    $display("xmodem_crc_sender_unit_tb: errors");
    $finish;
  end

  task automatic put(input logic [2:0] op, input logic [7:0] db, input logic lst);
    logic rdy;
    if ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    data_byte <= db;
    last_byte <= lst;
    do begin
      @(negedge clk_i);
      rdy = in_ready;
      @(posedge clk_i);
    end while (!rdy);
    beats_sent++;
  endtask

  task automatic noise();
    if ($urandom_range(99) < 3)
      put(3'($urandom_range(1, 7)), 8'($urandom), 1'($urandom));
  endtask

  // pause the sender until every result is back, then write the registers
  task automatic set_regs(input logic [7:0] tmo, input logic [7:0] naks);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (4) @(posedge clk_i);
    cfg_we <= 1'b1; cfg_idx <= RegTimeout; cfg_data <= tmo;
    @(posedge clk_i);
    cfg_idx <= RegMaxNaks; cfg_data <= naks;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_frame_bytes(output bit aborted);
    int tries;
    aborted = 1'b0;
    tries = 0;
    forever begin
      repeat (FramePayload + 5) begin
        put(OpSlot, 8'($urandom), 1'($urandom));
        noise();
      end
      tries++;
      case ($urandom_range(99)) inside
        [0:71]:  return;
        [72:81]: put(OpRx, ChNak, 1'b0);
        [82:87]: put(OpRx, $urandom_range(1) ? ChC : ChLf, 1'b0);
        [88:92]: put(OpRx, 8'($urandom), 1'b0);
        [93:96]: put(OpTick, 8'($urandom), 1'b0);
        default: begin
          put(OpRx, ChCan, 1'b0);
          aborted = 1'b1;
          return;
        end
      endcase
      if (tries > 5) return;
    end
  endtask

  task automatic transfer(input int len);
    int  sent, chunk;
    bit  aborted;
    transfers++;
    put(OpStart, 8'($urandom), 1'($urandom));
    if ($urandom_range(3) == 0) put(OpTick, 8'($urandom), 1'b0);
    if ($urandom_range(4) == 0) put(OpRx, 8'($urandom), 1'b0);
    put(OpRx, ChC, 1'b0);
    sent = 0;
    while (sent < len) begin
      chunk = (len - sent > FramePayload) ? FramePayload : len - sent;
      for (int i = 0; i < chunk; i++) begin
        put(OpData, 8'($urandom), (sent + i == len - 1));
        noise();
      end
      sent += chunk;
      send_frame_bytes(aborted);
      if (aborted) return;
      put(OpRx, ChAck, 1'b0);
    end
    // end of file: EOT, perhaps refused a few times
    forever begin
      put(OpSlot, 8'($urandom), 1'b0);
      if ($urandom_range(99) < 70) break;
      put(OpRx, ($urandom_range(1) ? ChNak : ChLf), 1'b0);
      if ($urandom_range(9) == 0) put(OpTick, 8'($urandom), 1'b0);
    end
    put(OpRx, ChAck, 1'b0);
  endtask

  task automatic run_phase(input int target);
    int len;
    while (beats_sent < target) begin
      case ($urandom_range(99)) inside
        [0:69]:  len = $urandom_range(1, 40);
        [70:94]: len = $urandom_range(41, 200);
        default: len = $urandom_range(129, 300);
      endcase
      transfer(len);
    end
  endtask

  initial begin
    snd_idle = 7; rcv_idle = 63;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle-state corner cases, unknown opcodes, timeout at the reset limit
    put(3'd5, 8'hFF, 1'b1);
    put(3'd6, 8'h00, 1'b0);
    put(3'd7, 8'hA5, 1'b1);
    put(OpSlot, 8'h00, 1'b0);
    put(OpData, 8'hFF, 1'b1);
    put(OpRx, ChC, 1'b0);
    put(OpTick, 8'h00, 1'b0);
    put(OpStart, 8'h00, 1'b0);
    repeat (3) put(OpTick, 8'h00, 1'b0);
    put(OpTick, 8'h00, 1'b0);
    put(OpStart, 8'hFF, 1'b1);
    put(OpRx, 8'h00, 1'b0);
    put(OpRx, ChC, 1'b0);
    put(OpData, 8'h00, 1'b0);
    put(OpData, 8'hFF, 1'b1);
    put(OpData, 8'h55, 1'b0);
    put(OpStart, 8'h00, 1'b0);
    transfer(128);

    run_phase(500);
    long_hold_req = 1'b1;
    run_phase(600);

    set_regs(8'd1, 8'd0);
    snd_idle = 63; rcv_idle = 7;
    run_phase(900);

    set_regs(8'd255, 8'd255);
    snd_idle = 0; rcv_idle = 0;
    run_phase(1150);

    set_regs(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)));
    run_phase(1350);

    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (10) @(posedge clk_i);
    $display("Run covered %0d beats in %0d transfers under four register settings;",
             beats_sent, transfers);
    $display("%0d result beats compared.", compared);
    if (fail_count == 0 && pending == 0) begin
      $display("xmodem_crc_sender_unit_tb: clean");
    end else begin
      $display("xmodem_crc_sender_unit_tb: errors");
    end
    $finish;
  end

endmodule
